// ===== sv/gmb_pkg.sv =====
// shared constants and the direction order table for the maze backtracker
package gmb_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_GOAL  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] CELL_WALL  = 2'd0;
    localparam logic [1:0] CELL_OPEN  = 2'd1;
    localparam logic [1:0] CELL_START = 2'd2;
    localparam logic [1:0] CELL_GOAL  = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam int PERM_COUNT = 24;

    // four 2-bit direction codes per order, first try in the top bits
    localparam logic [7:0] DIR_ORDER [PERM_COUNT] = '{
        8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39,
        8'h4B, 8'h4E, 8'h63, 8'h6C, 8'h72, 8'h78,
        8'h87, 8'h8D, 8'h93, 8'h9C, 8'hB1, 8'hB4,
        8'hC6, 8'hC9, 8'hD2, 8'hD8, 8'hE1, 8'hE4
    };

    function automatic logic [1:0] dir_of(input logic [4:0] perm, input logic [1:0] k);
        logic [7:0] e;
        logic [1:0] d;
        e = DIR_ORDER[perm];
        case (k)
            2'd0: d = e[7:6];
            2'd1: d = e[5:4];
            2'd2: d = e[3:2];
            default: d = e[1:0];
        endcase
        return d;
    endfunction

    function automatic logic [4:0] fix_perm(input logic [4:0] p);
        return (p >= 5'd24) ? 5'(p - 5'd24) : p;
    endfunction

endpackage

// ===== sv/gmb_ram.sv =====
// generic single write port, single read port ram with registered read
module gmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/grid_maze_backtracker.sv =====
// top level of the depth-first maze carver: control sequencer around cell and frame rams
//
// input channel (in_valid / in_stall) carries operation, row, col, perm; one result
// item per input item leaves on the output channel (out_valid / out_stall).
// cfg_valid / cfg_ready writes grid_rows (index 0) or grid_cols (index 1); cfg_ready
// is always high, write only while idle.
// one item is worked at a time; in_stall is low only in the idle state.
// after reset the cell ram is swept to wall, one entry a cycle, before any item is
// taken. a start item runs the same sweep, then marks the start cell if it lies in
// the grid.
// a step tries the directions of the top frame in order: one ruled out by the bounds
// is skipped, else the target cell is read; an exhausted frame is popped (frame ram
// read, no read for the last frame); a carve writes the target, then the middle cell.
// goal and read items read the addressed cell if it lies in the grid.
// the result sits in an output register; while out_stall is high it holds and the
// block waits with the next result, the input side stays stalled meanwhile.
module grid_maze_backtracker #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [5:0] row,
    input  logic [5:0] col,
    input  logic [4:0] perm,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       carved,
    output logic       finished,
    output logic       accepted,
    output logic [5:0] out_row,
    output logic [5:0] out_col,
    output logic [1:0] cell_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);
    import gmb_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SLOTS = (MAX_ROWS / 2) * (MAX_COLS / 2);
    localparam int FAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW    = $clog2(SLOTS + 1);
    localparam int FW    = RW + CW + 5 + 3;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_START   = 4'd2;
    localparam logic [3:0] S_EVAL    = 4'd3;
    localparam logic [3:0] S_CHECK   = 4'd4;
    localparam logic [3:0] S_CARVE2  = 4'd5;
    localparam logic [3:0] S_POPWAIT = 4'd6;
    localparam logic [3:0] S_GOALCHK = 4'd7;
    localparam logic [3:0] S_READCHK = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          start_pend_reg, start_pend_next;
    logic [6:0]    grid_rows_reg, grid_cols_reg;
    logic [DW-1:0] depth_reg, depth_next;

    logic [1:0]    op_reg;
    logic [5:0]    row_reg, col_reg;
    logic [4:0]    perm_reg;

    logic [RW-1:0] top_r_reg, top_r_next;
    logic [CW-1:0] top_c_reg, top_c_next;
    logic [4:0]    top_p_reg, top_p_next;
    logic [2:0]    top_n_reg, top_n_next;
    logic [RW-1:0] tgt_r_reg, tgt_r_next, mid_r_reg, mid_r_next;
    logic [CW-1:0] tgt_c_reg, tgt_c_next, mid_c_reg, mid_c_next;

    logic          res_carved_reg, res_carved_next;
    logic          res_acc_reg, res_acc_next;
    logic [1:0]    res_val_reg, res_val_next;

    logic          out_valid_reg, out_valid_next;
    logic          carved_reg, finished_reg, accepted_reg;
    logic [5:0]    out_row_reg, out_col_reg;
    logic [1:0]    cell_value_reg;

    logic [8:0]    eff_rows, eff_cols;
    logic          in_grid_in, in_grid_reg;
    logic          load_out;

    logic          cell_we, cell_re;
    logic [AW-1:0] cell_waddr, cell_raddr;
    logic [1:0]    cell_wdata, cell_rdata;
    logic          frm_we, frm_re;
    logic [FAW-1:0] frm_waddr, frm_raddr;
    logic [FW-1:0] frm_wdata, frm_rdata;

    logic [1:0]    dir;
    logic [9:0]    r10, c10;
    logic          move_ok;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(r * MAX_COLS + c);
    endfunction

    gmb_ram #(.WIDTH(2), .DEPTH(CELLS)) u_cells (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gmb_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_frames (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata (frm_wdata),
        .re    (frm_re),
        .raddr (frm_raddr),
        .rdata (frm_rdata)
    );

    assign eff_rows = ({2'b0, grid_rows_reg} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, grid_rows_reg};
    assign eff_cols = ({2'b0, grid_cols_reg} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, grid_cols_reg};
    assign in_grid_in  = ({3'b0, row} < eff_rows) && ({3'b0, col} < eff_cols);
    assign in_grid_reg = ({3'b0, row_reg} < eff_rows) && ({3'b0, col_reg} < eff_cols);

    assign dir = dir_of(top_p_reg, top_n_reg[1:0]);
    assign r10 = 10'(top_r_reg);
    assign c10 = 10'(top_c_reg);

    always_comb
    begin
        case (dir)
            DIR_UP:    move_ok = r10 >= 10'd3;
            DIR_RIGHT: move_ok = (c10 + 10'd3) < 10'(eff_cols);
            DIR_DOWN:  move_ok = (r10 + 10'd3) < 10'(eff_rows);
            default:   move_ok = c10 >= 10'd3;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        start_pend_next = start_pend_reg;
        depth_next      = depth_reg;
        top_r_next      = top_r_reg;
        top_c_next      = top_c_reg;
        top_p_next      = top_p_reg;
        top_n_next      = top_n_reg;
        tgt_r_next      = tgt_r_reg;
        tgt_c_next      = tgt_c_reg;
        mid_r_next      = mid_r_reg;
        mid_c_next      = mid_c_reg;
        res_carved_next = res_carved_reg;
        res_acc_next    = res_acc_reg;
        res_val_next    = res_val_reg;
        cell_we    = 1'b0;
        cell_waddr = clr_cnt_reg;
        cell_wdata = CELL_WALL;
        cell_re    = 1'b0;
        cell_raddr = cell_addr(RW'(row_reg), CW'(col_reg));
        frm_we     = 1'b0;
        frm_waddr  = FAW'(depth_reg - DW'(1));
        frm_wdata  = {top_r_reg, top_c_reg, top_p_reg, top_n_reg};
        frm_re     = 1'b0;
        frm_raddr  = FAW'(depth_reg - DW'(2));

        unique case (state_reg)
            S_CLEAR:
            begin
                cell_we = 1'b1;
                if (clr_cnt_reg == AW'(CELLS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = start_pend_reg ? S_START : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_carved_next = 1'b0;
                    res_acc_next    = 1'b0;
                    res_val_next    = CELL_WALL;
                    cell_raddr      = cell_addr(RW'(row), CW'(col));
                    unique case (operation)
                        OP_START:
                        begin
                            depth_next      = '0;
                            start_pend_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        OP_STEP:
                        begin
                            state_next = S_EVAL;
                        end
                        OP_GOAL:
                        begin
                            cell_re    = in_grid_in;
                            state_next = in_grid_in ? S_GOALCHK : S_DONE;
                        end
                        default:
                        begin
                            cell_re    = in_grid_in;
                            state_next = in_grid_in ? S_READCHK : S_DONE;
                        end
                    endcase
                end
            end
            S_START:
            begin
                start_pend_next = 1'b0;
                if (in_grid_reg)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = cell_addr(RW'(row_reg), CW'(col_reg));
                    cell_wdata = CELL_START;
                    depth_next = DW'(1);
                    top_r_next = RW'(row_reg);
                    top_c_next = CW'(col_reg);
                    top_p_next = perm_reg;
                    top_n_next = 3'd0;
                end
                state_next = S_DONE;
            end
            S_EVAL:
            begin
                if (depth_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (top_n_reg[2])
                begin
                    // frame exhausted: pop it and, unless it was the last one, refill the top from the frame ram
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg >= DW'(2))
                    begin
                        frm_re     = 1'b1;
                        state_next = S_POPWAIT;
                    end
                end
                else
                begin
                    top_n_next = top_n_reg + 3'd1;
                    unique case (dir)
                        DIR_UP:
                        begin
                            tgt_r_next = top_r_reg - RW'(2);
                            mid_r_next = top_r_reg - RW'(1);
                            tgt_c_next = top_c_reg;
                            mid_c_next = top_c_reg;
                        end
                        DIR_RIGHT:
                        begin
                            tgt_r_next = top_r_reg;
                            mid_r_next = top_r_reg;
                            tgt_c_next = top_c_reg + CW'(2);
                            mid_c_next = top_c_reg + CW'(1);
                        end
                        DIR_DOWN:
                        begin
                            tgt_r_next = top_r_reg + RW'(2);
                            mid_r_next = top_r_reg + RW'(1);
                            tgt_c_next = top_c_reg;
                            mid_c_next = top_c_reg;
                        end
                        default:
                        begin
                            tgt_r_next = top_r_reg;
                            mid_r_next = top_r_reg;
                            tgt_c_next = top_c_reg - CW'(2);
                            mid_c_next = top_c_reg - CW'(1);
                        end
                    endcase
                    if (move_ok)
                    begin
                        cell_re    = 1'b1;
                        cell_raddr = cell_addr(tgt_r_next, tgt_c_next);
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (cell_rdata == CELL_WALL && depth_reg < DW'(SLOTS))
                begin
                    cell_we         = 1'b1;
                    cell_waddr      = cell_addr(tgt_r_reg, tgt_c_reg);
                    cell_wdata      = CELL_OPEN;
                    // spill the current top, the new cell becomes the top
                    frm_we          = 1'b1;
                    depth_next      = depth_reg + DW'(1);
                    top_r_next      = tgt_r_reg;
                    top_c_next      = tgt_c_reg;
                    top_p_next      = perm_reg;
                    top_n_next      = 3'd0;
                    res_carved_next = 1'b1;
                    state_next      = S_CARVE2;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_CARVE2:
            begin
                cell_we    = 1'b1;
                cell_waddr = cell_addr(mid_r_reg, mid_c_reg);
                cell_wdata = CELL_OPEN;
                state_next = S_DONE;
            end
            S_POPWAIT:
            begin
                {top_r_next, top_c_next, top_p_next, top_n_next} = frm_rdata;
                state_next = S_EVAL;
            end
            S_GOALCHK:
            begin
                if (cell_rdata == CELL_OPEN)
                begin
                    cell_we      = 1'b1;
                    cell_waddr   = cell_addr(RW'(row_reg), CW'(col_reg));
                    cell_wdata   = CELL_GOAL;
                    res_acc_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_READCHK:
            begin
                res_val_next = cell_rdata;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            start_pend_reg <= 1'b0;
            depth_reg      <= '0;
            grid_rows_reg  <= 7'd64;
            grid_cols_reg  <= 7'd64;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            start_pend_reg <= start_pend_next;
            depth_reg      <= depth_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == 1'b0)
                begin
                    grid_rows_reg <= cfg_data;
                end
                else
                begin
                    grid_cols_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= operation;
            row_reg  <= row;
            col_reg  <= col;
            perm_reg <= fix_perm(perm);
        end
        top_r_reg      <= top_r_next;
        top_c_reg      <= top_c_next;
        top_p_reg      <= top_p_next;
        top_n_reg      <= top_n_next;
        tgt_r_reg      <= tgt_r_next;
        tgt_c_reg      <= tgt_c_next;
        mid_r_reg      <= mid_r_next;
        mid_c_reg      <= mid_c_next;
        res_carved_reg <= res_carved_next;
        res_acc_reg    <= res_acc_next;
        res_val_reg    <= res_val_next;
        if (load_out)
        begin
            carved_reg     <= res_carved_reg;
            finished_reg   <= (depth_reg == '0);
            accepted_reg   <= res_acc_reg;
            out_row_reg    <= res_carved_reg ? 6'(top_r_reg) : 6'd0;
            out_col_reg    <= res_carved_reg ? 6'(top_c_reg) : 6'd0;
            cell_value_reg <= (op_reg == OP_READ) ? res_val_reg : CELL_WALL;
        end
    end

    assign out_valid  = out_valid_reg;
    assign carved     = carved_reg;
    assign finished   = finished_reg;
    assign accepted   = accepted_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign cell_value = cell_value_reg;

endmodule
